/* hw/rtl/bdq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque package
// Request and result payload types, operation codes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

    // Operation codes carried in the op field of a request.
    localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_REMOVE     = 3'd4;
    localparam logic [2:0] OP_LIST       = 3'd5;

    // Incoming request.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] item;
    } t_req;

    // Outgoing result.
    typedef struct packed {
        logic [31:0] item_out;
        logic        item_valid;
        logic        ok;
        logic [4:0]  count;
        logic [31:0] head_item;
        logic [31:0] tail_item;
        logic        last;
    } t_res;

    // Datapath actions requested by the controller.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP,
        ACT_POP_FILL,
        ACT_WALK_START,
        ACT_WALK,
        ACT_REM_DONE,
        ACT_REPORT
    } t_act;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        t_act act;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       walk_last;
    } t_sts;

endpackage

/* hw/rtl/bdq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bdq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque controller
// Sequences each request through execute, fill, walk and remove-done steps and
// issues one action per cycle to the datapath.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output bdq_pkg::t_cmd  o_cmd,
    input  bdq_pkg::t_sts  i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_FILL,
        S_WALK,
        S_REM_DONE
    } t_state;

    t_state r_state;
    logic   r_busy;

    // State register with the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    case (i_sts.op)
                        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                            if (i_sts.empty) begin
                                r_state <= S_IDLE;
                                r_busy  <= 1'b0;
                            end else begin
                                r_state <= S_POP_FILL;
                            end
                        end
                        bdq_pkg::OP_REMOVE, bdq_pkg::OP_LIST: begin
                            if (i_sts.empty) begin
                                r_state <= S_IDLE;
                                r_busy  <= 1'b0;
                            end else begin
                                r_state <= S_WALK;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                            r_busy  <= 1'b0;
                        end
                    endcase
                end
                S_POP_FILL: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                S_WALK: begin
                    if (i_sts.walk_last) begin
                        if (i_sts.op == bdq_pkg::OP_REMOVE) begin
                            r_state <= S_REM_DONE;
                        end else begin
                            r_state <= S_IDLE;
                            r_busy  <= 1'b0;
                        end
                    end
                end
                S_REM_DONE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;

    // Action decode for the current state.
    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.act  = bdq_pkg::ACT_NONE;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                case (i_sts.op)
                    bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT: begin
                        o_cmd.act = i_sts.full ? bdq_pkg::ACT_REPORT : bdq_pkg::ACT_PUSH;
                    end
                    bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                        o_cmd.act = i_sts.empty ? bdq_pkg::ACT_REPORT : bdq_pkg::ACT_POP;
                    end
                    bdq_pkg::OP_REMOVE, bdq_pkg::OP_LIST: begin
                        o_cmd.act = i_sts.empty ? bdq_pkg::ACT_REPORT
                                                : bdq_pkg::ACT_WALK_START;
                    end
                    default: begin
                        o_cmd.act = bdq_pkg::ACT_REPORT;
                    end
                endcase
            end
            S_POP_FILL: begin
                o_cmd.act = bdq_pkg::ACT_POP_FILL;
            end
            S_WALK: begin
                o_cmd.act = bdq_pkg::ACT_WALK;
            end
            S_REM_DONE: begin
                o_cmd.act = bdq_pkg::ACT_REM_DONE;
            end
            default: begin
                o_cmd.act = bdq_pkg::ACT_NONE;
            end
        endcase
    end

    // A walk is only ever entered with entries to visit.
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !i_sts.empty)
        else $error("walk running over an empty store");

    // Busy tracks the state: low exactly when idle.
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy flag out of step with state");

    // A request is only captured while idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("request captured while busy");

endmodule

/* hw/rtl/bdq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque datapath
// Ring store with head index and count, shadow registers for the first and
// last entries, the walk counters for remove and list, and the result
// register.
// ----------------------------------------------------------------------------
module bdq_dpath #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bdq_pkg::t_cmd  i_cmd,
    input  bdq_pkg::t_req  i_req,
    output bdq_pkg::t_sts  o_sts,
    output bdq_pkg::t_res  o_res,
    output logic           o_strobe
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Ring position of an offset from the given base.
    function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // Zero-extend or truncate an item word to the 32-bit result fields.
    function automatic logic [31:0] to32(input logic [ITEM_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    logic [2:0]            r_op,       n_op;
    logic [ITEM_WIDTH-1:0] r_val,      n_val;
    logic [IW-1:0]         r_head_idx, n_head_idx;
    logic [CW-1:0]         r_count,    n_count;
    logic [ITEM_WIDTH-1:0] r_head_val, n_head_val;
    logic [ITEM_WIDTH-1:0] r_tail_val, n_tail_val;
    logic [ITEM_WIDTH-1:0] r_item,     n_item;
    logic [CW-1:0]         r_rd_i,     n_rd_i;
    logic [CW-1:0]         r_tk_i,     n_tk_i;
    logic [CW-1:0]         r_n,        n_n;
    logic                  r_found,    n_found;
    bdq_pkg::t_res         r_res,      n_res;
    logic                  r_strobe,   n_strobe;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    logic [63:0]           req_wide;
    logic [63:0]           cnt_wide;
    logic                  walk_last;
    logic                  e_emit;
    logic [ITEM_WIDTH-1:0] e_item;
    logic                  e_valid;
    logic                  e_ok;
    logic                  e_last;

    bdq_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign req_wide  = 64'(i_req.item);
    assign walk_last = (r_tk_i == r_count - CW'(1));

    // Status for the controller.
    assign o_sts.op        = r_op;
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == CW'(DEPTH));
    assign o_sts.walk_last = walk_last;

    // Next-state logic for every action.
    always_comb begin
        n_op       = r_op;
        n_val      = r_val;
        n_head_idx = r_head_idx;
        n_count    = r_count;
        n_head_val = r_head_val;
        n_tail_val = r_tail_val;
        n_item     = r_item;
        n_rd_i     = r_rd_i;
        n_tk_i     = r_tk_i;
        n_n        = r_n;
        n_found    = r_found;
        ram_we     = 1'b0;
        ram_waddr  = r_head_idx;
        ram_wdata  = r_val;
        ram_raddr  = r_head_idx;
        e_emit     = 1'b0;
        e_item     = '0;
        e_valid    = 1'b0;
        e_ok       = 1'b0;
        e_last     = 1'b1;

        // Capture an accepted request.
        if (i_cmd.load) begin
            n_op  = i_req.op;
            n_val = req_wide[ITEM_WIDTH-1:0];
        end

        case (i_cmd.act)
            bdq_pkg::ACT_PUSH: begin
                ram_we  = 1'b1;
                n_count = r_count + CW'(1);
                e_emit  = 1'b1;
                e_ok    = 1'b1;
                if (r_op == bdq_pkg::OP_PUSH_BACK) begin
                    ram_waddr  = ring(r_head_idx, r_count);
                    n_tail_val = r_val;
                    if (r_count == '0) begin
                        n_head_val = r_val;
                    end
                end else begin
                    n_head_idx = (r_head_idx == '0) ? IW'(DEPTH - 1)
                                                    : r_head_idx - IW'(1);
                    ram_waddr  = n_head_idx;
                    n_head_val = r_val;
                    if (r_count == '0) begin
                        n_tail_val = r_val;
                    end
                end
            end
            bdq_pkg::ACT_POP: begin
                // Hand out the shadowed end and fetch its new neighbour.
                n_count = r_count - CW'(1);
                if (r_op == bdq_pkg::OP_POP_FRONT) begin
                    n_item     = r_head_val;
                    n_head_idx = ring(r_head_idx, CW'(1));
                    ram_raddr  = n_head_idx;
                end else begin
                    n_item    = r_tail_val;
                    ram_raddr = ring(r_head_idx, r_count - CW'(2));
                end
            end
            bdq_pkg::ACT_POP_FILL: begin
                if (r_count != '0) begin
                    if (r_op == bdq_pkg::OP_POP_FRONT) begin
                        n_head_val = ram_rdata;
                    end else begin
                        n_tail_val = ram_rdata;
                    end
                end
                e_emit  = 1'b1;
                e_item  = r_item;
                e_valid = 1'b1;
                e_ok    = 1'b1;
            end
            bdq_pkg::ACT_WALK_START: begin
                ram_raddr = r_head_idx;
                n_rd_i    = CW'(1);
                n_tk_i    = '0;
                n_n       = '0;
                n_found   = 1'b0;
            end
            bdq_pkg::ACT_WALK: begin
                // Read ahead one entry while the previous one is handled.
                if (r_rd_i < r_count) begin
                    ram_raddr = ring(r_head_idx, r_rd_i);
                    n_rd_i    = r_rd_i + CW'(1);
                end
                n_tk_i = r_tk_i + CW'(1);
                if (r_op == bdq_pkg::OP_LIST) begin
                    e_emit  = 1'b1;
                    e_item  = ram_rdata;
                    e_valid = 1'b1;
                    e_ok    = 1'b1;
                    e_last  = walk_last;
                end else if (ram_rdata == r_val) begin
                    n_found = 1'b1;
                end else begin
                    // Compact kept entries towards the front, in place.
                    ram_we     = 1'b1;
                    ram_waddr  = ring(r_head_idx, r_n);
                    ram_wdata  = ram_rdata;
                    n_n        = r_n + CW'(1);
                    n_tail_val = ram_rdata;
                    if (r_n == '0) begin
                        n_head_val = ram_rdata;
                    end
                end
            end
            bdq_pkg::ACT_REM_DONE: begin
                n_count = r_n;
                e_emit  = 1'b1;
                e_ok    = r_found;
            end
            bdq_pkg::ACT_REPORT: begin
                e_emit = 1'b1;
            end
            default: begin
                e_emit = 1'b0;
            end
        endcase
    end

    // Result fields reflect the state after the action.
    assign cnt_wide = 64'(n_count);

    always_comb begin
        n_strobe         = e_emit;
        n_res            = r_res;
        if (e_emit) begin
            n_res.item_out   = to32(e_item);
            n_res.item_valid = e_valid;
            n_res.ok         = e_ok;
            n_res.count      = cnt_wide[4:0];
            n_res.head_item  = (n_count == '0) ? 32'd0 : to32(n_head_val);
            n_res.tail_item  = (n_count == '0) ? 32'd0 : to32(n_tail_val);
            n_res.last       = e_last;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_idx <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_head_idx <= n_head_idx;
            r_count    <= n_count;
            r_strobe   <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_val      <= n_val;
        r_head_val <= n_head_val;
        r_tail_val <= n_tail_val;
        r_item     <= n_item;
        r_rd_i     <= n_rd_i;
        r_tk_i     <= n_tk_i;
        r_n        <= n_n;
        r_found    <= n_found;
        r_res      <= n_res;
    end

    assign o_res    = r_res;
    assign o_strobe = r_strobe;

    // The store never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // A push adds exactly one entry.
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == bdq_pkg::ACT_PUSH) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not add one entry");

    // Compaction never keeps more entries than it has visited.
    a_kept_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act == bdq_pkg::ACT_WALK) |-> (r_n <= r_tk_i))
        else $error("remove kept more entries than it read");

    // A result only follows an action that produces one.
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ($past(i_cmd.act) != bdq_pkg::ACT_NONE))
        else $error("result strobe without a cause");

endmodule

/* hw/rtl/bounded_deque_with_remove.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded double-ended queue with remove
// A deque of up to DEPTH item words with push and pop at both ends, removal
// of every entry equal to a value, and a listing of all entries.
// ----------------------------------------------------------------------------
// Usage:
//   A request (i_req: op and item) is taken at a rising edge where start is
//   high and busy is low. Results appear on o_res for one cycle each, marked
//   by o_strobe; every result carries the count and the first and last
//   entries after the operation, and o_res.last flags the final one.
//   List results come one per cycle, front first. Pop re-reads the new end
//   through the single read port of the entry RAM, and remove and list visit
//   one entry per cycle, remove compacting in place through the write port.
//   Reset clears the count and head index; the entry RAM is not cleared and
//   no preparation pass is needed, so requests are taken straight away.
//   The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module bounded_deque_with_remove #(
    parameter int DEPTH      = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bdq_pkg::t_req i_req,
    output bdq_pkg::t_res o_res,
    output logic          o_strobe
);

    bdq_pkg::t_cmd cmd;
    bdq_pkg::t_sts sts;

    // Sequencing.
    bdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Storage and result formation.
    bdq_dpath #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_req    (i_req),
        .o_sts    (sts),
        .o_res    (o_res),
        .o_strobe (o_strobe)
    );

endmodule
